// ===== rtl/core/planar_code_deframer_assert.svh =====
// assertion macros for the planar code deframer checker
// no dependencies; included by the checker file
`ifndef PLANAR_CODE_DEFRAMER_ASSERT_SVH
`define PLANAR_CODE_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled while reset is low
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/core/pcd_pkg.sv =====
// shared types and constants of the planar code deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_BIG_ENDIAN = 1'b0;

  // graph phase codes
  localparam int unsigned PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_COUNT = 2'd1;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam logic [PHASE_W-1:0] PHASE_LIST  = 2'd2;

  // one result item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last_in_graph;
    logic              truncated;
  } pcd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcd_cfg_regs.sv =====
// configuration register file (byte order) behind an apb-style port
// depends on pcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pcd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pcd_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic                               big_endian_o
);

  logic big_endian_q;
  logic big_endian_d;
  logic hit_be;

  assign pready = 1'b1;
  assign hit_be = (paddr[pcd_pkg::PADDR_W-1:2] == pcd_pkg::REG_BIG_ENDIAN);

  // write on the access cycle
  always_comb begin
    big_endian_d = big_endian_q;
    if (psel && penable && pwrite && pready && hit_be) begin
      big_endian_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else begin
      big_endian_q <= big_endian_d;
    end
  end

  // read back
  assign prdata = hit_be ? {{(pcd_pkg::PDATA_W-1){1'b0}}, big_endian_q}
                         : '0;

  assign big_endian_o = big_endian_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcd_word_fsm.sv =====
// graph framing state: word assembly, vertex counting, truncation
// depends on pcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcd_word_fsm (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [pcd_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic                           stream_end_i,
  input  wire logic                           big_endian_i,
  output logic                                res_valid_o,
  output pcd_pkg::pcd_result_t                res_o
);

  logic [pcd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                        two_q, two_d;
  logic                        pend_q, pend_d;
  logic [pcd_pkg::BYTE_W-1:0]  held_q, held_d;
  logic [pcd_pkg::WORD_W-1:0]  vleft_q, vleft_d;

  logic                        have_word;
  logic [pcd_pkg::WORD_W-1:0]  word;
  logic [pcd_pkg::PHASE_W-1:0] word_phase;
  logic [pcd_pkg::WORD_W-1:0]  vleft_dec;

  assign vleft_dec = vleft_q - pcd_pkg::WORD_W'(1);

  always_comb begin
    phase_d     = phase_q;
    two_d       = two_q;
    pend_d      = pend_q;
    held_d      = held_q;
    vleft_d     = vleft_q;
    have_word   = 1'b0;
    word        = {{(pcd_pkg::WORD_W-pcd_pkg::BYTE_W){1'b0}}, data_byte_i};
    word_phase  = phase_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // byte handling and word assembly
    if (accept_i) begin
      if (stream_end_i) begin
        if (phase_q != pcd_pkg::PHASE_IDLE) begin
          phase_d           = pcd_pkg::PHASE_IDLE;
          two_d             = 1'b0;
          pend_d            = 1'b0;
          vleft_d           = '0;
          res_valid_o       = 1'b1;
          res_o.truncated   = 1'b1;
        end
      end else if (phase_q == pcd_pkg::PHASE_IDLE) begin
        phase_d = pcd_pkg::PHASE_COUNT;
        pend_d  = 1'b0;
        if (data_byte_i == '0) begin
          two_d = 1'b1;
        end else begin
          two_d      = 1'b0;
          have_word  = 1'b1;
          word_phase = pcd_pkg::PHASE_COUNT;
        end
      end else if (!two_q) begin
        have_word = 1'b1;
      end else if (!pend_q) begin
        held_d = data_byte_i;
        pend_d = 1'b1;
      end else begin
        pend_d    = 1'b0;
        have_word = 1'b1;
        word      = big_endian_i ? {held_q, data_byte_i} : {data_byte_i, held_q};
      end
    end

    // complete word: vertex count or list entry
    if (have_word) begin
      res_valid_o = 1'b1;
      res_o.word  = word;
      if (word_phase == pcd_pkg::PHASE_COUNT) begin
        if (word == '0) begin
          phase_d             = pcd_pkg::PHASE_IDLE;
          two_d               = 1'b0;
          vleft_d             = '0;
          res_o.last_in_graph = 1'b1;
        end else begin
          vleft_d = word;
          phase_d = pcd_pkg::PHASE_LIST;
        end
      end else if (word == '0) begin
        vleft_d = vleft_dec;
        if (vleft_dec == '0) begin
          phase_d             = pcd_pkg::PHASE_IDLE;
          two_d               = 1'b0;
          res_o.last_in_graph = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcd_pkg::PHASE_IDLE;
      two_q   <= 1'b0;
      pend_q  <= 1'b0;
      vleft_q <= '0;
    end else begin
      phase_q <= phase_d;
      two_q   <= two_d;
      pend_q  <= pend_d;
      vleft_q <= vleft_d;
    end
  end

  // held byte is payload, read only while a byte is pending
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcd_out_reg.sv =====
// output register stage with valid/stall handshake
// depends on pcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcd_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire pcd_pkg::pcd_result_t  res_i,
  input  wire logic                  out_stall_i,
  output logic                       full_stall_o,
  output logic                       out_valid_o,
  output pcd_pkg::pcd_result_t       res_o
);

  logic                 valid_q, valid_d;
  pcd_pkg::pcd_result_t res_q, res_d;
  logic                 open_slot;

  // the register can take a new item when empty or being drained
  assign open_slot    = !valid_q || !out_stall_i;
  assign full_stall_o = !open_slot;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (open_slot) begin
      valid_d = load_i;
      if (load_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/planar_code_deframer.sv =====
// planar code deframer: one item per cycle unless stalled, result registered in the cycle after acceptance
// throughput is one item per cycle, set by the single output register stage;
// input stalls only while the output register holds an item that is stalled
// rst_ni (async, active low) clears framing state, output valid and byte order
// depends on pcd_pkg, pcd_cfg_regs, pcd_word_fsm, pcd_out_reg
`timescale 1ns / 1ps
`default_nettype none

module planar_code_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pcd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pcd_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pcd_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          stream_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [pcd_pkg::WORD_W-1:0]    word_o,
  output logic                               last_in_graph_o,
  output logic                               truncated_o
);

  logic                 big_endian;
  logic                 accept;
  logic                 res_valid;
  pcd_pkg::pcd_result_t res;
  pcd_pkg::pcd_result_t res_out;

  assign accept = in_valid_i && !in_stall_o;

  // configuration
  pcd_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .big_endian_o (big_endian)
  );

  // framing state
  pcd_word_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .stream_end_i (stream_end_i),
    .big_endian_i (big_endian),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register
  pcd_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_valid),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .full_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .res_o        (res_out)
  );

  assign word_o          = res_out.word;
  assign last_in_graph_o = res_out.last_in_graph;
  assign truncated_o     = res_out.truncated;

endmodule

`default_nettype wire

// ===== rtl/core/pcd_checker.sv =====
// port-level checks of the planar code deframer, bound to the top level
// depends on pcd_pkg and planar_code_deframer_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "planar_code_deframer_assert.svh"

module pcd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [pcd_pkg::WORD_W-1:0]  word_o,
  input wire logic                        last_in_graph_o,
  input wire logic                        truncated_o
);

  // a truncation item carries no word and never closes a graph
  `PCD_ASSERT_IMPLY(a_trunc_clean, clk_i, rst_ni, out_valid_o && truncated_o,
                    word_o == '0 && !last_in_graph_o)

  // a stalled full output register blocks the input
  `PCD_ASSERT_IMPLY(a_full_stalls, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)

  // an empty output register never stalls the input
  `PCD_ASSERT_IMPLY(a_empty_open, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // a stalled result holds
  `PCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(word_o) && $stable(truncated_o))

endmodule

bind planar_code_deframer pcd_checker u_pcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .word_o          (word_o),
  .last_in_graph_o (last_in_graph_o),
  .truncated_o     (truncated_o)
);

`default_nettype wire

// ===== dv/tb_planar_code_deframer.sv =====
// testbench for planar_code_deframer: directed and random byte streams against a local predictor
// depends on pcd_pkg and the planar_code_deframer rtl; needs no files or arguments
`timescale 1ns / 1ps

module tb_planar_code_deframer;
  import pcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned MAX_PRINTS = 50;
  localparam logic [PADDR_W-1:0] ADDR_BIG_ENDIAN = PADDR_W'(4 * REG_BIG_ENDIAN);

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // block ports
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [BYTE_W-1:0]  data_byte_i = '0;
  logic               stream_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WORD_W-1:0]  word_o;
  logic               last_in_graph_o;
  logic               truncated_o;

  planar_code_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .stream_end_i    (stream_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_o          (word_o),
    .last_in_graph_o (last_in_graph_o),
    .truncated_o     (truncated_o)
  );

  // predicted framing state
  logic [PHASE_W-1:0] m_phase = PHASE_IDLE;
  logic               m_two_byte = 1'b0;
  logic               m_pending = 1'b0;
  logic [BYTE_W-1:0]  m_held = '0;
  logic [WORD_W-1:0]  m_vertices_left = '0;
  logic               m_big_endian = 1'b0;

  pcd_result_t words_due[$];
  bit [BYTE_W-1:0] graph_bytes[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  function automatic void go_idle();
    m_phase = PHASE_IDLE;
    m_two_byte = 1'b0;
    m_pending = 1'b0;
    m_held = '0;
    m_vertices_left = '0;
  endfunction

  // one complete code word: vertex count or vertex list entry
  function automatic pcd_result_t take_word(logic [WORD_W-1:0] w);
    pcd_result_t r;
    r = '0;
    r.word = w;
    if (m_phase == PHASE_COUNT) begin
      if (w == '0) begin
        go_idle();
        r.last_in_graph = 1'b1;
      end else begin
        m_vertices_left = w;
        m_phase = PHASE_LIST;
      end
    end else if (w == '0) begin
      m_vertices_left = m_vertices_left - 1'b1;
      if (m_vertices_left == '0) begin
        go_idle();
        r.last_in_graph = 1'b1;
      end
    end
    return r;
  endfunction

  // predicts the result of one accepted item; returns 1 when one is due
  function automatic bit deframe_item(logic [BYTE_W-1:0] b, logic eos, output pcd_result_t r);
    r = '0;
    if (eos) begin
      if (m_phase == PHASE_IDLE) return 1'b0;
      go_idle();
      r.truncated = 1'b1;
      return 1'b1;
    end
    if (m_phase == PHASE_IDLE) begin
      m_phase = PHASE_COUNT;
      if (b == '0) begin
        m_two_byte = 1'b1;
        m_pending = 1'b0;
        return 1'b0;
      end
      m_two_byte = 1'b0;
      r = take_word({8'h00, b});
      return 1'b1;
    end
    if (!m_two_byte) begin
      r = take_word({8'h00, b});
      return 1'b1;
    end
    if (!m_pending) begin
      m_held = b;
      m_pending = 1'b1;
      return 1'b0;
    end
    m_pending = 1'b0;
    r = take_word(m_big_endian ? {m_held, b} : {b, m_held});
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h", cycle_count, what, want, got);
  endtask

  // sends one item; called right after a rising edge, returns at its acceptance edge
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
    int unsigned gap;
    pcd_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    stream_end_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (deframe_item(b, eos, r)) words_due.push_back(r);
  endtask

  task automatic send_end();
    send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // waits until every due word has arrived and the pipeline has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // byte order change with readback, only while the block is idle
  task automatic set_byte_order(input logic be);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    apb_write(ADDR_BIG_ENDIAN, PDATA_W'(be));
    m_big_endian = be;
    // the bus goes idle between the write and the read
    @(posedge clk_i);
    apb_read(ADDR_BIG_ENDIAN, rd);
    if (rd != PDATA_W'(be)) report_mismatch("big_endian readback", PDATA_W'(be), rd);
  endtask

  function automatic void add_word(logic [WORD_W-1:0] w);
    if (m_big_endian) begin
      graph_bytes.push_back(w[15:8]);
      graph_bytes.push_back(w[7:0]);
    end else begin
      graph_bytes.push_back(w[7:0]);
      graph_bytes.push_back(w[15:8]);
    end
  endfunction

  // builds one well-formed graph with random content into graph_bytes
  function automatic void build_graph();
    bit two;
    int unsigned nv;
    int unsigned k;
    graph_bytes.delete();
    two = $urandom_range(0, 1);
    nv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    if (!two && nv == 0) nv = 1;
    if (two) begin
      graph_bytes.push_back(8'h00);
      add_word(WORD_W'(nv));
    end else begin
      graph_bytes.push_back(BYTE_W'(nv));
    end
    for (int v = 0; v < nv; v++) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) begin
        if (two) add_word(WORD_W'($urandom_range(1, 65535)));
        else graph_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
      end
      if (two) add_word('0);
      else graph_bytes.push_back(8'h00);
    end
  endfunction

  // single-byte graphs, end between graphs, end inside a graph
  task automatic test_single_byte();
    send_item(8'h01, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'h02, 1'b0); send_item(8'hFF, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0); send_item(8'h00, 1'b0);
    send_end();
    send_item(8'h03, 1'b0); send_item(8'h05, 1'b0); send_end();
  endtask

  // two-byte mode: zero count, end after mode byte, end with half a word held
  task automatic test_two_byte();
    send_item(8'h00, 1'b0); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0); send_end();
    send_item(8'h00, 1'b0); send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0); send_end();
  endtask

  // byte order flipped in the middle of a graph
  task automatic test_mid_graph_order();
    set_byte_order(1'b0);
    send_item(8'h00, 1'b0); send_item(8'h01, 1'b0); send_item(8'h00, 1'b0);
    set_byte_order(1'b1);
    send_item(8'hFF, 1'b0); send_item(8'hFE, 1'b0);
    send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
  endtask

  // random graphs, some cut short, plus noise followed by a resync end
  task automatic test_random(input int unsigned n_items);
    int unsigned target;
    int unsigned cut;
    int unsigned k;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        build_graph();
        cut = graph_bytes.size();
        if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, graph_bytes.size());
        for (int i = 0; i < cut; i++) send_item(graph_bytes[i], 1'b0);
        if (cut != graph_bytes.size()) send_end();
      end else begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++)
          send_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        send_end();
      end
    end
  endtask

  // receiver stall pattern
  int unsigned stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (no_idle || $urandom_range(0, 1)) begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b1;
      stall_run = pick_gap();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pcd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) begin
        report_mismatch("unexpected result word", 0, word_o);
      end else begin
        want = words_due.pop_front();
        if (word_o !== want.word) report_mismatch("word", want.word, word_o);
        if (last_in_graph_o !== want.last_in_graph)
          report_mismatch("last_in_graph", want.last_in_graph, last_in_graph_o);
        if (truncated_o !== want.truncated)
          report_mismatch("truncated", want.truncated, truncated_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte();
    test_two_byte();
    test_mid_graph_order();
    for (int ph = 0; ph < 4; ph++) begin
      set_byte_order(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      no_idle = (ph == 2);
      test_random(RANDOM_ITEMS / 4);
    end
    no_idle = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
